// ===== rtl/core/mfi_pkg.sv =====
// Shared types, constants, microcode table and arithmetic helpers for the magnet fractal iterator.
`default_nettype none
package mfi_pkg;

  localparam int COORD_BITS = 12;
  localparam int ITER_BITS  = 16;
  localparam int FRAC       = 28;
  localparam int ZW         = 48;
  localparam int PC_W       = 5;

  typedef logic signed [ZW-1:0] fx_t;

  localparam fx_t ZMAX   = 48'sh7FFF_FFFF_FFFF;
  localparam fx_t FX_ONE = 48'sh0000_1000_0000;
  localparam fx_t FX_TWO = 48'sh0000_2000_0000;

  typedef struct packed {
    fx_t  val;
    logic ovf;
  } fx_res_t;

  typedef enum logic [2:0] {
    CFG_MODE,
    CFG_MAX_ITER,
    CFG_PALETTE,
    CFG_MIN_X,
    CFG_MAX_Y,
    CFG_X_STEP,
    CFG_Y_STEP
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_MAGT,
    OP_DENT
  } op_t;

  typedef enum logic [4:0] {
    R_ZR, R_ZI, R_CR, R_CI, R_A, R_B, R_P, R_S, R_T,
    R_NR, R_NI, R_DR, R_DI, R_DEN, R_QR, R_QI, R_ONE, R_TWO
  } rsel_t;

  typedef struct packed {
    op_t   op;
    rsel_t a;
    rsel_t b;
    rsel_t dst;
    logic  last;
  } uop_t;

  typedef struct packed {
    logic load;
    logic init;
    logic clr;
    logic go;
    uop_t u;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic fault;
    logic mag_gt;
    logic den_zero;
    logic zr_pos;
    logic zi_pos;
    logic zi_neg;
  } dp_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_TOP,
    ST_EXEC,
    ST_WAIT,
    ST_END,
    ST_DONE
  } state_t;

  function automatic uop_t ucode(logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      5'd0:  u = '{OP_MUL,  R_ZR, R_ZR,  R_A,   1'b0};
      5'd1:  u = '{OP_MUL,  R_ZI, R_ZI,  R_B,   1'b0};
      5'd2:  u = '{OP_ADD,  R_A,  R_B,   R_S,   1'b0};
      5'd3:  u = '{OP_MAGT, R_S,  R_S,   R_S,   1'b0};
      5'd4:  u = '{OP_MUL,  R_ZR, R_ZI,  R_P,   1'b0};
      5'd5:  u = '{OP_SUB,  R_A,  R_B,   R_S,   1'b0};
      5'd6:  u = '{OP_ADD,  R_P,  R_P,   R_T,   1'b0};
      5'd7:  u = '{OP_ADD,  R_S,  R_CR,  R_NR,  1'b0};
      5'd8:  u = '{OP_SUB,  R_NR, R_ONE, R_NR,  1'b0};
      5'd9:  u = '{OP_ADD,  R_T,  R_CI,  R_NI,  1'b0};
      5'd10: u = '{OP_ADD,  R_ZR, R_ZR,  R_DR,  1'b0};
      5'd11: u = '{OP_ADD,  R_DR, R_CR,  R_DR,  1'b0};
      5'd12: u = '{OP_SUB,  R_DR, R_TWO, R_DR,  1'b0};
      5'd13: u = '{OP_ADD,  R_ZI, R_ZI,  R_DI,  1'b0};
      5'd14: u = '{OP_ADD,  R_DI, R_CI,  R_DI,  1'b0};
      5'd15: u = '{OP_MUL,  R_DR, R_DR,  R_A,   1'b0};
      5'd16: u = '{OP_MUL,  R_DI, R_DI,  R_B,   1'b0};
      5'd17: u = '{OP_ADD,  R_A,  R_B,   R_DEN, 1'b0};
      5'd18: u = '{OP_DENT, R_DEN, R_DEN, R_DEN, 1'b0};
      5'd19: u = '{OP_MUL,  R_NR, R_DR,  R_A,   1'b0};
      5'd20: u = '{OP_MUL,  R_NI, R_DI,  R_B,   1'b0};
      5'd21: u = '{OP_ADD,  R_A,  R_B,   R_S,   1'b0};
      5'd22: u = '{OP_DIV,  R_S,  R_DEN, R_QR,  1'b0};
      5'd23: u = '{OP_MUL,  R_NI, R_DR,  R_A,   1'b0};
      5'd24: u = '{OP_MUL,  R_NR, R_DI,  R_B,   1'b0};
      5'd25: u = '{OP_SUB,  R_A,  R_B,   R_S,   1'b0};
      5'd26: u = '{OP_DIV,  R_S,  R_DEN, R_QI,  1'b0};
      5'd27: u = '{OP_MUL,  R_QR, R_QR,  R_A,   1'b0};
      5'd28: u = '{OP_MUL,  R_QI, R_QI,  R_B,   1'b0};
      5'd29: u = '{OP_SUB,  R_A,  R_B,   R_ZR,  1'b0};
      5'd30: u = '{OP_MUL,  R_QR, R_QI,  R_P,   1'b0};
      5'd31: u = '{OP_ADD,  R_P,  R_P,   R_ZI,  1'b1};
      default: u = '{OP_ADD, R_P, R_P, R_ZI, 1'b1};
    endcase
    return u;
  endfunction

  function automatic fx_res_t fx_addsub(fx_t a, fx_t b, logic sub);
    logic signed [ZW:0] s;
    fx_res_t r;
    s = sub ? ((ZW+1)'(a) - (ZW+1)'(b)) : ((ZW+1)'(a) + (ZW+1)'(b));
    if (s > (ZW+1)'(ZMAX)) begin
      r.val = ZMAX;
      r.ovf = 1'b1;
    end else if (s < -((ZW+1)'(ZMAX))) begin
      r.val = -ZMAX;
      r.ovf = 1'b1;
    end else begin
      r.val = s[ZW-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/magnet_fractal_pixel_iterator_unit.sv =====
// Top level of the magnet fractal pixel iterator: configuration registers and unit wiring.
//
//   channel  signals                          direction
//   input    in_valid/in_stall, pixel_x/y     in, stall out
//   output   out_valid/out_stall, color,      out, stall in
//            inside_res
//   config   cfg_valid/cfg_ready, cfg_index,  in, ready out (always ready)
//            cfg_data
//
// One pixel at a time. Accept and setup pass through the IDLE and INIT states; a full
// iteration runs twelve multiplies, two bit-serial divides, sixteen adds on the shared
// saturating adder, the magnitude and denominator tests and the TOP and END sequencing states.
// A finished result sits in the output register while the next pixel is taken;
// the next result holds the sequencer until the first one transfers.
// Reset restores register defaults; no clearing pass is needed.
`default_nettype none
module magnet_fractal_pixel_iterator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [11:0] pixel_x,
  input  wire logic [11:0] pixel_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [16:0]      color,
  output logic             inside_res,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import mfi_pkg::*;

  logic               mode;
  logic [15:0]        max_iter;
  logic [15:0]        palette_size;
  logic signed [31:0] min_x;
  logic signed [31:0] max_y;
  logic [30:0]        x_step;
  logic [30:0]        y_step;
  dp_cmd_t            dp_cmd;
  dp_stat_t           dp_stat;
  logic [ITER_BITS-1:0] lim;

  assign cfg_ready = 1'b1;
  assign lim       = ITER_BITS'(max_iter);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= 1'b0;
      max_iter     <= 16'd256;
      palette_size <= 16'd256;
      min_x        <= 32'shE000_0000;
      max_y        <= 32'sh2000_0000;
      x_step       <= 31'd1677722;
      y_step       <= 31'd1677722;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:     mode         <= cfg_data[0];
        CFG_MAX_ITER: max_iter     <= cfg_data[15:0];
        CFG_PALETTE:  palette_size <= cfg_data[15:0];
        CFG_MIN_X:    min_x        <= cfg_data;
        CFG_MAX_Y:    max_y        <= cfg_data;
        CFG_X_STEP:   x_step       <= cfg_data[30:0];
        CFG_Y_STEP:   y_step       <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  mfi_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .lim          (lim),
    .mode         (mode),
    .palette_size (palette_size),
    .stat         (dp_stat),
    .cmd          (dp_cmd),
    .color        (color),
    .inside_res   (inside_res)
  );

  mfi_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (dp_cmd),
    .px     (COORD_BITS'(pixel_x)),
    .py     (COORD_BITS'(pixel_y)),
    .lim    (lim),
    .min_x  (min_x),
    .max_y  (max_y),
    .x_step (x_step),
    .y_step (y_step),
    .stat   (dp_stat)
  );

  a_load_no_go: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.load |-> !dp_cmd.go)
    else $error("load issued together with an operation");

  a_done_no_go: assert property (@(posedge clk) disable iff (rst)
    dp_stat.done |-> !dp_cmd.go)
    else $error("operation issued while a unit completes");

  a_mul_latency: assert property (@(posedge clk) disable iff (rst)
    (dp_cmd.go && (dp_cmd.u.op == OP_MUL || dp_cmd.u.op == OP_DIV)) |=> !dp_stat.done)
    else $error("multi-cycle unit finished too early");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transfer accepted during setup");

endmodule
`default_nettype wire

// ===== rtl/core/mfi_mul.sv =====
// Multi-cycle saturating Q20.28 multiplier built from four partial products.
`default_nettype none
module mfi_mul (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire mfi_pkg::fx_t a,
  input  wire mfi_pkg::fx_t b,
  output logic              done,
  output mfi_pkg::fx_t      res,
  output logic              ovf
);
  import mfi_pkg::*;

  localparam int HW = ZW - 1 - FRAC;

  logic              busy;
  logic [2:0]        cnt;
  logic [ZW-2:0]     ua;
  logic [ZW-2:0]     ub;
  logic              neg;
  logic [2*FRAC-1:0] prod;
  logic [2*HW-1:0]   hh;
  logic [ZW+1:0]     acc;
  logic [FRAC-1:0]   opx;
  logic [FRAC-1:0]   opy;
  logic [ZW+1:0]     r;
  logic [ZW-2:0]     mag;
  fx_t               a_abs;
  fx_t               b_abs;

  assign a_abs = a[ZW-1] ? -a : a;
  assign b_abs = b[ZW-1] ? -b : b;

  always_comb begin
    case (cnt)
      3'd0: begin
        opx = FRAC'(ua[ZW-2:FRAC]);
        opy = FRAC'(ub[ZW-2:FRAC]);
      end
      3'd1: begin
        opx = FRAC'(ua[ZW-2:FRAC]);
        opy = ub[FRAC-1:0];
      end
      3'd2: begin
        opx = ua[FRAC-1:0];
        opy = FRAC'(ub[ZW-2:FRAC]);
      end
      default: begin
        opx = ua[FRAC-1:0];
        opy = ub[FRAC-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        ua   <= a_abs[ZW-2:0];
        ub   <= b_abs[ZW-2:0];
        neg  <= a[ZW-1] ^ b[ZW-1];
      end else if (busy) begin
        cnt  <= cnt + 3'd1;
        prod <= opx * opy;
        case (cnt)
          3'd1: hh <= prod[2*HW-1:0];
          3'd2: acc <= (ZW+2)'(prod);
          3'd3: acc <= acc + (ZW+2)'(prod);
          3'd4: begin
            acc  <= acc + (ZW+2)'(prod[2*FRAC-1:FRAC]);
            busy <= 1'b0;
            done <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  assign r   = {(ZW+2-HW-FRAC)'(0), hh[HW-1:0], FRAC'(0)} + acc;
  assign ovf = (|hh[2*HW-1:HW]) || (r > (ZW+2)'(ZMAX));
  assign mag = ovf ? ZMAX[ZW-2:0] : r[ZW-2:0];
  assign res = neg ? -fx_t'({1'b0, mag}) : fx_t'({1'b0, mag});

endmodule
`default_nettype wire

// ===== rtl/core/mfi_div.sv =====
// Bit-serial restoring divider giving a saturating Q20.28 quotient.
`default_nettype none
module mfi_div (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire mfi_pkg::fx_t n,
  input  wire mfi_pkg::fx_t d,
  output logic              done,
  output mfi_pkg::fx_t      res,
  output logic              ovf
);
  import mfi_pkg::*;

  localparam int NW   = ZW - 1 + FRAC;
  localparam int HIGH = NW - (ZW - 1);

  logic            busy;
  logic [6:0]      cnt;
  logic [NW-1:0]   dvd;
  logic [ZW-2:0]   rem;
  logic [ZW-2:0]   dv;
  logic [ZW-2:0]   quo;
  logic            ovf_q;
  logic            neg;
  logic [ZW-1:0]   trial;
  logic            ge;
  logic [ZW-2:0]   mag;
  fx_t             n_abs;

  assign n_abs = n[ZW-1] ? -n : n;
  assign trial = {rem, dvd[NW-1]};
  assign ge    = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        dvd   <= {n_abs[ZW-2:0], FRAC'(0)};
        rem   <= '0;
        dv    <= d[ZW-2:0];
        quo   <= '0;
        ovf_q <= 1'b0;
        neg   <= n[ZW-1];
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        dvd <= dvd << 1;
        rem <= ge ? (ZW-1)'(trial - {1'b0, dv}) : trial[ZW-2:0];
        quo <= {quo[ZW-3:0], ge};
        if (ge && (cnt < 7'(HIGH))) begin
          ovf_q <= 1'b1;
        end
        if (cnt == 7'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign ovf = ovf_q;
  assign mag = ovf_q ? ZMAX[ZW-2:0] : quo;
  assign res = neg ? -fx_t'({1'b0, mag}) : fx_t'({1'b0, mag});

endmodule
`default_nettype wire

// ===== rtl/core/mfi_dpath.sv =====
// Iteration datapath: operand registers, saturating adder, shared multiplier and divider.
`default_nettype none
module mfi_dpath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire mfi_pkg::dp_cmd_t                cmd,
  input  wire logic [mfi_pkg::COORD_BITS-1:0]  px,
  input  wire logic [mfi_pkg::COORD_BITS-1:0]  py,
  input  wire logic [mfi_pkg::ITER_BITS-1:0]   lim,
  input  wire logic signed [31:0]              min_x,
  input  wire logic signed [31:0]              max_y,
  input  wire logic [30:0]                     x_step,
  input  wire logic [30:0]                     y_step,
  output mfi_pkg::dp_stat_t                    stat
);
  import mfi_pkg::*;

  localparam int PW = COORD_BITS + 31;

  fx_t zr, zi, cr, ci, ra, rb, rp, rs, rt, nr, ni, dr, di, den, qr, qi;
  logic [PW-1:0] xprod;
  logic [PW-1:0] yprod;
  logic          fault;
  fx_t           va;
  fx_t           vb;
  fx_res_t       sum;
  logic          mul_done, div_done, mul_ovf, div_ovf;
  fx_t           mul_res, div_res;
  logic          wen;
  fx_t           wval;
  logic          wovf;
  logic signed [63:0] cr_raw;
  logic signed [63:0] ci_raw;

  function automatic fx_t rd(rsel_t s, fx_t zr_i, fx_t zi_i, fx_t cr_i, fx_t ci_i,
                             fx_t a_i, fx_t b_i, fx_t p_i, fx_t s_i, fx_t t_i,
                             fx_t nr_i, fx_t ni_i, fx_t dr_i, fx_t di_i,
                             fx_t den_i, fx_t qr_i, fx_t qi_i);
    fx_t v;
    unique case (s)
      R_ZR:  v = zr_i;
      R_ZI:  v = zi_i;
      R_CR:  v = cr_i;
      R_CI:  v = ci_i;
      R_A:   v = a_i;
      R_B:   v = b_i;
      R_P:   v = p_i;
      R_S:   v = s_i;
      R_T:   v = t_i;
      R_NR:  v = nr_i;
      R_NI:  v = ni_i;
      R_DR:  v = dr_i;
      R_DI:  v = di_i;
      R_DEN: v = den_i;
      R_QR:  v = qr_i;
      R_QI:  v = qi_i;
      R_ONE: v = FX_ONE;
      R_TWO: v = FX_TWO;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic fx_t clampc(logic signed [63:0] v);
    fx_t r;
    if (v > 64'(ZMAX)) begin
      r = ZMAX;
    end else if (v < -(64'(ZMAX))) begin
      r = -ZMAX;
    end else begin
      r = v[ZW-1:0];
    end
    return r;
  endfunction

  assign va  = rd(cmd.u.a, zr, zi, cr, ci, ra, rb, rp, rs, rt, nr, ni, dr, di, den, qr, qi);
  assign vb  = rd(cmd.u.b, zr, zi, cr, ci, ra, rb, rp, rs, rt, nr, ni, dr, di, den, qr, qi);
  assign sum = fx_addsub(va, vb, cmd.u.op == OP_SUB);

  mfi_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.go && (cmd.u.op == OP_MUL)),
    .a     (va),
    .b     (vb),
    .done  (mul_done),
    .res   (mul_res),
    .ovf   (mul_ovf)
  );

  mfi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.go && (cmd.u.op == OP_DIV)),
    .n     (va),
    .d     (vb),
    .done  (div_done),
    .res   (div_res),
    .ovf   (div_ovf)
  );

  always_comb begin
    wen  = 1'b0;
    wval = sum.val;
    wovf = 1'b0;
    if (cmd.go && ((cmd.u.op == OP_ADD) || (cmd.u.op == OP_SUB))) begin
      wen  = 1'b1;
      wval = sum.val;
      wovf = sum.ovf;
    end else if (mul_done) begin
      wen  = 1'b1;
      wval = mul_res;
      wovf = mul_ovf;
    end else if (div_done) begin
      wen  = 1'b1;
      wval = div_res;
      wovf = div_ovf;
    end
  end

  assign cr_raw = 64'(min_x) + 64'(xprod);
  assign ci_raw = 64'(max_y) - 64'(yprod);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xprod <= PW'(px) * PW'(x_step);
      yprod <= PW'(py) * PW'(y_step);
    end
    if (cmd.init) begin
      cr <= clampc(cr_raw);
      ci <= clampc(ci_raw);
      zr <= '0;
      zi <= '0;
    end else if (wen) begin
      case (cmd.u.dst)
        R_ZR:  zr  <= wval;
        R_ZI:  zi  <= wval;
        R_A:   ra  <= wval;
        R_B:   rb  <= wval;
        R_P:   rp  <= wval;
        R_S:   rs  <= wval;
        R_T:   rt  <= wval;
        R_NR:  nr  <= wval;
        R_NI:  ni  <= wval;
        R_DR:  dr  <= wval;
        R_DI:  di  <= wval;
        R_DEN: den <= wval;
        R_QR:  qr  <= wval;
        R_QI:  qi  <= wval;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault <= 1'b0;
    end else if (cmd.clr) begin
      fault <= 1'b0;
    end else if (wen && wovf) begin
      fault <= 1'b1;
    end
  end

  assign stat.done     = mul_done || div_done;
  assign stat.fault    = fault;
  assign stat.mag_gt   = !rs[ZW-1] && (64'(rs[ZW-2:0]) > (64'(lim) << FRAC));
  assign stat.den_zero = (den == '0);
  assign stat.zr_pos   = !zr[ZW-1] && (zr != '0);
  assign stat.zi_pos   = !zi[ZW-1] && (zi != '0);
  assign stat.zi_neg   = zi[ZW-1];

endmodule
`default_nettype wire

// ===== rtl/core/mfi_ctrl.sv =====
// Sequencer state machine: walks the iteration microcode and builds the result.
`default_nettype none
module mfi_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  input  wire logic [mfi_pkg::ITER_BITS-1:0]  lim,
  input  wire logic                           mode,
  input  wire logic [15:0]                    palette_size,
  input  wire mfi_pkg::dp_stat_t              stat,
  output mfi_pkg::dp_cmd_t                    cmd,
  output logic [16:0]                         color,
  output logic                                inside_res
);
  import mfi_pkg::*;

  state_t                state, state_next;
  logic [PC_W-1:0]       pc, pc_next;
  logic [ITER_BITS-1:0]  n, n_next;
  logic                  bad, bad_next;
  logic                  stay_in, stay_in_next;
  logic [15:0]           offset;
  logic [17:0]           tri_ps;
  logic                  emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pc      <= '0;
      n       <= '0;
      bad     <= 1'b0;
      stay_in <= 1'b1;
    end else begin
      state   <= state_next;
      pc      <= pc_next;
      n       <= n_next;
      bad     <= bad_next;
      stay_in <= stay_in_next;
    end
  end

  always_comb begin
    state_next   = state;
    pc_next      = pc;
    n_next       = n;
    bad_next     = bad;
    stay_in_next = stay_in;
    cmd          = '0;
    cmd.u        = ucode(pc);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        n_next     = '0;
        bad_next   = 1'b0;
        state_next = ST_TOP;
      end
      ST_TOP: begin
        if (n == lim) begin
          stay_in_next = 1'b1;
          state_next   = ST_DONE;
        end else if (bad) begin
          stay_in_next = 1'b0;
          state_next   = ST_DONE;
        end else begin
          cmd.clr    = 1'b1;
          pc_next    = '0;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (cmd.u.op) inside
          OP_ADD, OP_SUB: begin
            cmd.go = 1'b1;
            if (cmd.u.last) begin
              state_next = ST_END;
            end else begin
              pc_next = pc + 1'b1;
            end
          end
          OP_MUL, OP_DIV: begin
            cmd.go     = 1'b1;
            state_next = ST_WAIT;
          end
          OP_MAGT: begin
            if (stat.fault || stat.mag_gt) begin
              stay_in_next = 1'b0;
              state_next   = ST_DONE;
            end else begin
              pc_next = pc + 1'b1;
            end
          end
          OP_DENT: begin
            if (stat.den_zero) begin
              bad_next   = 1'b1;
              n_next     = n + 1'b1;
              state_next = ST_TOP;
            end else begin
              pc_next = pc + 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_WAIT: begin
        if (stat.done) begin
          if (cmd.u.last) begin
            state_next = ST_END;
          end else begin
            pc_next    = pc + 1'b1;
            state_next = ST_EXEC;
          end
        end
      end
      ST_END: begin
        bad_next   = bad || stat.fault;
        n_next     = n + 1'b1;
        state_next = ST_TOP;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_stall = (state != ST_IDLE);
  assign tri_ps   = 18'(palette_size) + 18'({palette_size, 1'b0});
  assign emit     = (state == ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    if (stat.zr_pos && stat.zi_pos) begin
      offset = 16'd1;
    end else if (!stat.zr_pos && stat.zi_pos) begin
      offset = palette_size >> 2;
    end else if (!stat.zr_pos && stat.zi_neg) begin
      offset = palette_size >> 1;
    end else begin
      offset = tri_ps[17:2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      color      <= mode ? (17'(n) + 17'(offset)) : 17'(n);
      inside_res <= stay_in;
    end
  end

endmodule
`default_nettype wire
